### rtl/wfbp_pkg.sv
// ----------------------------------------------------------------------------
// wfbp_pkg
// Shared constants and types of the windowed FFT band power block.
// ----------------------------------------------------------------------------
package wfbp_pkg;

    localparam int CFG_AW     = 5;
    localparam int CFG_DW     = 32;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 72;
    localparam int WIN_DEPTH  = 512;
    localparam int ACC_DEPTH  = 256;
    localparam int POWER_W    = 62;
    localparam int BAND_IDX_W = 6;

    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [63:0] POWER_MAX  = 64'h3FFF_FFFF_FFFF_FFFF;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        REG_WINDOW_LENGTH = 3'd0,
        REG_BIN_WIDTH     = 3'd1,
        REG_BAND_COUNT    = 3'd2,
        REG_CHANNEL_COUNT = 3'd3,
        REG_GAIN          = 3'd4
    } t_reg_idx;

endpackage

### rtl/windowed_fft_band_power.sv
// ----------------------------------------------------------------------------
// windowed_fft_band_power
// One frame of a power spectrogram: windowing, radix-2 FFT, band binning.
// ----------------------------------------------------------------------------
// channel  | dir | beat contents
// s_axis   | in  | tdata: coef_index[8:0], value[24:9]; tuser: command
// m_axis   | out | tdata: band_index[5:0], band_power[67:6]; tlast: last_band
// apb      | cfg | window_length, bin_width, band_count, channel_count, gain
//
// A coefficient load is taken when idle, a sample passes W_MUL and W_WR. A
// channel end adds FFT_SIZE-len zero writes, (FFT_SIZE/2)*log2(FFT_SIZE)
// butterflies (RD, LD, P1-P4, WA, WB; no P1-P4 when the twiddle is one) and
// per power bin RD and M0-M2, on the shared 33x33 multiplier. A frame end adds
// per band RD and ADD per bin, S0-S2 and OUT. No clearing pass after reset.
// Band output stalls only hold the sequencer; input is taken again once idle.
// ----------------------------------------------------------------------------
module windowed_fft_band_power #(
    parameter int FFT_SIZE     = 512,
    parameter int BANDS_MAX    = 64,
    parameter int CHANNELS_MAX = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // coef_index, value
    input  logic [wfbp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // command
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // band_index, band_power
    output logic [wfbp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wfbp_pkg::CFG_AW-1:0]     paddr,
    input  logic [wfbp_pkg::CFG_DW-1:0]     pwdata,
    output logic [wfbp_pkg::CFG_DW-1:0]     prdata,
    output logic                            pready
);
    import wfbp_pkg::*;

    localparam int LOG2N  = $clog2(FFT_SIZE);
    localparam int HALF_N = FFT_SIZE / 2;
    localparam int LIMIT  = FFT_SIZE < WIN_DEPTH ? FFT_SIZE : WIN_DEPTH;
    localparam int SCW    = $clog2(LIMIT);
    localparam int NBINS  = HALF_N < ACC_DEPTH ? HALF_N : ACC_DEPTH;
    localparam int ACW    = $clog2(NBINS);
    localparam int DW     = LOG2N + 18;
    localparam int JW     = LOG2N - 1;
    localparam int STW    = $clog2(LOG2N);
    localparam int BW     = $clog2(BANDS_MAX + 1);
    localparam int IDXW   = $clog2(BANDS_MAX * 512);
    localparam int MW     = 33;
    localparam int PW     = 2 * MW;

    typedef logic [31:0] t_tw_rom [HALF_N];

    typedef enum logic [4:0] {
        ST_IDLE, ST_W_MUL, ST_W_WR, ST_ZERO,
        ST_BF_RD, ST_BF_LD, ST_BF_P1, ST_BF_P2, ST_BF_P3, ST_BF_P4, ST_BF_WA, ST_BF_WB,
        ST_PW_RD, ST_PW_M0, ST_PW_M1, ST_PW_M2,
        ST_BD_RD, ST_BD_ADD, ST_BD_S0, ST_BD_S1, ST_BD_S2, ST_BD_OUT
    } t_state;

    function automatic logic [15:0] q30_to_q15(logic signed [63:0] v);
        logic signed [63:0] t;
        t = (v < 0) ? 64'sd0 : v;
        t = (t + 64'sd16384) >>> 15;
        return (t > 64'sd32767) ? 16'd32767 : t[15:0];
    endfunction

    // {sin, cos} of 2 pi j / FFT_SIZE by a seven-term series
    function automatic logic [31:0] octant(logic [63:0] j);
        logic [63:0] x, x2, ts, tc;
        logic signed [63:0] ss, cs;
        x  = TWO_PI_Q30 * j / FFT_SIZE;
        x2 = (x * x) >> 30;
        ts = x;
        tc = 64'd1 << 30;
        ss = signed'(x);
        cs = signed'(tc);
        ts = ((ts * x2) >> 30) / 6;   tc = ((tc * x2) >> 30) / 2;
        ss = ss - signed'(ts);        cs = cs - signed'(tc);
        ts = ((ts * x2) >> 30) / 20;  tc = ((tc * x2) >> 30) / 12;
        ss = ss + signed'(ts);        cs = cs + signed'(tc);
        ts = ((ts * x2) >> 30) / 42;  tc = ((tc * x2) >> 30) / 30;
        ss = ss - signed'(ts);        cs = cs - signed'(tc);
        ts = ((ts * x2) >> 30) / 72;  tc = ((tc * x2) >> 30) / 56;
        ss = ss + signed'(ts);        cs = cs + signed'(tc);
        ts = ((ts * x2) >> 30) / 110; tc = ((tc * x2) >> 30) / 90;
        ss = ss - signed'(ts);        cs = cs - signed'(tc);
        ts = ((ts * x2) >> 30) / 156; tc = ((tc * x2) >> 30) / 132;
        ss = ss + signed'(ts);        cs = cs + signed'(tc);
        return {q30_to_q15(ss), q30_to_q15(cs)};
    endfunction

    // entry: {cos[31:16], sin[15:0]}
    function automatic t_tw_rom build_tw();
        t_tw_rom rom;
        logic [31:0] sc;
        for (int k = 0; k < HALF_N; k++) begin
            if (8 * k <= FFT_SIZE) begin
                sc = octant(64'(k));
                rom[k] = {sc[15:0], sc[31:16]};
            end else if (8 * k <= 2 * FFT_SIZE) begin
                sc = octant(64'(FFT_SIZE / 4 - k));
                rom[k] = {sc[31:16], sc[15:0]};
            end else if (8 * k <= 3 * FFT_SIZE) begin
                sc = octant(64'(k - FFT_SIZE / 4));
                rom[k] = {16'(-sc[31:16]), sc[15:0]};
            end else begin
                sc = octant(64'(FFT_SIZE / 2 - k));
                rom[k] = {16'(-sc[15:0]), sc[31:16]};
            end
        end
        return rom;
    endfunction

    localparam t_tw_rom TW_ROM = build_tw();

    function automatic logic [LOG2N-1:0] bitrev(logic [LOG2N-1:0] v);
        logic [LOG2N-1:0] r;
        for (int b = 0; b < LOG2N; b++) begin
            r[b] = v[LOG2N-1-b];
        end
        return r;
    endfunction

    function automatic logic signed [DW-1:0] rnd15(logic signed [PW:0] v);
        logic signed [PW:0] u;
        u = (v + (PW+1)'(16384)) >>> 15;
        return u[DW-1:0];
    endfunction

    t_state r_state;
    logic [9:0]  r_wl;
    logic [8:0]  r_bw;
    logic [6:0]  r_bc;
    logic [1:0]  r_ch;
    logic [31:0] r_gain;

    logic [SCW-1:0]  r_sc;
    logic            r_cc;
    logic [LOG2N-1:0] r_z;
    logic [STW-1:0]  r_stage;
    logic [JW-1:0]   r_j;
    logic [ACW-1:0]  r_i;
    logic [BW-1:0]   r_b;
    logic [8:0]      r_k;
    logic [IDXW-1:0] r_idx;
    logic            r_inrange;
    logic [63:0]     r_sum;
    logic [63:0]     r_band;
    logic signed [15:0] r_val;
    logic signed [15:0] r_coef;
    logic [2*DW-1:0] r_ra, r_rb;
    logic [31:0]     r_twd;
    logic [63:0]     r_accrd;
    logic signed [PW-1:0] r_acc, r_prod;
    logic signed [DW-1:0] r_tr, r_ti;
    logic            r_out_valid, r_out_last;
    logic [BAND_IDX_W-1:0] r_out_idx;
    logic [POWER_W-1:0]    r_out_pow;

    logic [15:0]     r_win [WIN_DEPTH];
    logic [2*DW-1:0] r_fft [FFT_SIZE];
    logic [63:0]     r_pacc [NBINS];

    logic in_acc, cfg_wr;
    logic [SCW:0] len, sc_p1;
    logic [1:0]   chans;
    logic [BW-1:0] bands;
    logic [8:0]   width;
    logic         cc_last;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign pready = 1'b1;

    always_comb begin
        if (r_wl == 10'd0) len = (SCW+1)'(1);
        else if (r_wl > LIMIT) len = (SCW+1)'(LIMIT);
        else len = r_wl[SCW:0];
        if (r_ch == 2'd0) chans = 2'd1;
        else if (r_ch > CHANNELS_MAX) chans = 2'(CHANNELS_MAX);
        else chans = r_ch;
        if (r_bc == 7'd0) bands = BW'(1);
        else if (r_bc > BANDS_MAX) bands = BW'(BANDS_MAX);
        else bands = BW'(r_bc);
        width = (r_bw == 9'd0) ? 9'd1 : r_bw;
    end
    assign sc_p1 = {1'b0, r_sc} + (SCW+1)'(1);
    assign cc_last = (chans != 2'd2) || r_cc;

    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_WINDOW_LENGTH: prdata = 32'(r_wl);
            REG_BIN_WIDTH:     prdata = 32'(r_bw);
            REG_BAND_COUNT:    prdata = 32'(r_bc);
            REG_CHANNEL_COUNT: prdata = 32'(r_ch);
            REG_GAIN:          prdata = r_gain;
            default:           prdata = '0;
        endcase
    end

    // butterfly addressing
    logic [JW-1:0]    bf_mask, bf_k, bf_twi;
    logic [LOG2N-1:0] bf_a, bf_b;
    always_comb begin
        bf_mask = JW'((1 << r_stage) - 1);
        bf_k    = r_j & bf_mask;
        bf_a    = {r_j & ~bf_mask, 1'b0} | {1'b0, bf_k};
        bf_b    = bf_a | LOG2N'(1 << r_stage);
        bf_twi  = JW'(bf_k << (JW - int'(r_stage)));
    end

    logic signed [DW-1:0] ar, ai, br, bi;
    logic signed [15:0]   tw_c, tw_s;
    assign ar   = r_ra[2*DW-1:DW];
    assign ai   = r_ra[DW-1:0];
    assign br   = r_rb[2*DW-1:DW];
    assign bi   = r_rb[DW-1:0];
    assign tw_c = r_twd[31:16];
    assign tw_s = r_twd[15:0];

    // shared multiplier operands
    logic signed [MW-1:0] mul_a, mul_b;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_W_MUL: begin mul_a = MW'(r_val); mul_b = MW'(r_coef); end
            ST_BF_LD: begin mul_a = MW'(tw_c);  mul_b = MW'(br); end
            ST_BF_P1: begin mul_a = MW'(tw_s);  mul_b = MW'(bi); end
            ST_BF_P2: begin mul_a = MW'(tw_c);  mul_b = MW'(bi); end
            ST_BF_P3: begin mul_a = MW'(tw_s);  mul_b = MW'(br); end
            ST_PW_M0: begin mul_a = MW'(ar);    mul_b = MW'(ar); end
            ST_PW_M1: begin mul_a = MW'(ai);    mul_b = MW'(ai); end
            ST_BD_S0: begin mul_a = {1'b0, r_sum[63:32]}; mul_b = {1'b0, r_gain}; end
            ST_BD_S1: begin mul_a = {1'b0, r_sum[31:0]};  mul_b = {1'b0, r_gain}; end
            default: ;
        endcase
    end

    // fft buffer ports
    logic             fft_we, fft_re;
    logic [LOG2N-1:0] fft_wa, fft_ra;
    logic [2*DW-1:0]  fft_wd;
    always_comb begin
        fft_we = 1'b0;
        fft_wa = '0;
        fft_wd = '0;
        fft_re = 1'b0;
        fft_ra = bf_a;
        case (r_state)
            ST_W_WR: begin
                fft_we = 1'b1;
                fft_wa = bitrev(LOG2N'(r_sc));
                fft_wd = {rnd15((PW+1)'(r_prod)), {DW{1'b0}}};
            end
            ST_ZERO: begin
                fft_we = 1'b1;
                fft_wa = bitrev(r_z);
            end
            ST_BF_WA: begin
                fft_we = 1'b1;
                fft_wa = bf_a;
                fft_wd = {ar + r_tr, ai + r_ti};
            end
            ST_BF_WB: begin
                fft_we = 1'b1;
                fft_wa = bf_b;
                fft_wd = {ar - r_tr, ai - r_ti};
            end
            ST_BF_RD: fft_re = 1'b1;
            ST_PW_RD: begin
                fft_re = 1'b1;
                fft_ra = LOG2N'(r_i);
            end
            default: ;
        endcase
    end

    logic [63:0] pw_p, pw_new, bd_add, bd_scaled;
    logic [64:0] pw_sum, bd_sum;
    always_comb begin
        pw_p   = 64'(r_acc) + 64'(r_prod);
        pw_sum = {1'b0, r_accrd} + {1'b0, pw_p};
        pw_new = !r_cc ? pw_p : (pw_sum[64] ? '1 : pw_sum[63:0]);
        bd_add = !r_inrange ? 64'd0 : ((chans == 2'd2) ? (r_accrd >> 1) : r_accrd);
        bd_sum = {1'b0, r_sum} + {1'b0, bd_add};
        bd_scaled = r_acc[63:0] + {32'd0, r_prod[63:32]};
    end

    logic             acc_we;
    logic [ACW-1:0]   acc_ra;
    assign acc_we = (r_state == ST_PW_M2);
    assign acc_ra = (r_state == ST_BD_RD) ? r_idx[ACW-1:0] : r_i;

    always_ff @(posedge i_clk) begin
        if (in_acc && s_axis_tuser == CMD_LOAD) begin
            r_win[s_axis_tdata[8:0]] <= s_axis_tdata[24:9];
        end
        if (in_acc && s_axis_tuser == CMD_SAMPLE) begin
            r_coef <= r_win[9'(r_sc)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fft_we) begin
            r_fft[fft_wa] <= fft_wd;
        end
        if (fft_re) begin
            r_ra <= r_fft[fft_ra];
            r_rb <= r_fft[bf_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            r_pacc[r_i] <= pw_new;
        end
        if (r_state == ST_PW_RD || r_state == ST_BD_RD) begin
            r_accrd <= r_pacc[acc_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (r_state == ST_BF_RD) begin
            r_twd <= TW_ROM[bf_twi];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wl        <= 10'd512;
            r_bw        <= 9'd1;
            r_bc        <= 7'd64;
            r_ch        <= 2'd1;
            r_gain      <= 32'hFFFF_FFFF;
            r_sc        <= '0;
            r_cc        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (t_reg_idx'(paddr[4:2]))
                    REG_WINDOW_LENGTH: r_wl   <= pwdata[9:0];
                    REG_BIN_WIDTH:     r_bw   <= pwdata[8:0];
                    REG_BAND_COUNT:    r_bc   <= pwdata[6:0];
                    REG_CHANNEL_COUNT: r_ch   <= pwdata[1:0];
                    REG_GAIN:          r_gain <= pwdata;
                    default: ;
                endcase
            end
            // in the output step the band beat register is handled below
            if (m_axis_tready && r_state != ST_BD_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc && s_axis_tuser == CMD_SAMPLE) begin
                        r_val   <= s_axis_tdata[24:9];
                        r_state <= ST_W_MUL;
                    end
                end
                ST_W_MUL: r_state <= ST_W_WR;
                ST_W_WR: begin
                    r_stage <= '0;
                    r_j     <= '0;
                    if (sc_p1 < len) begin
                        r_sc    <= r_sc + SCW'(1);
                        r_state <= ST_IDLE;
                    end else begin
                        r_sc <= '0;
                        if (sc_p1 < FFT_SIZE) begin
                            r_z     <= LOG2N'(sc_p1);
                            r_state <= ST_ZERO;
                        end else begin
                            r_state <= ST_BF_RD;
                        end
                    end
                end
                ST_ZERO: begin
                    r_z <= r_z + LOG2N'(1);
                    if (r_z == LOG2N'(FFT_SIZE - 1)) begin
                        r_state <= ST_BF_RD;
                    end
                end
                ST_BF_RD: r_state <= ST_BF_LD;
                ST_BF_LD: begin
                    if (bf_k == '0) begin
                        r_tr    <= br;
                        r_ti    <= bi;
                        r_state <= ST_BF_WA;
                    end else begin
                        r_state <= ST_BF_P1;
                    end
                end
                ST_BF_P1: begin
                    r_acc   <= r_prod;
                    r_state <= ST_BF_P2;
                end
                ST_BF_P2: begin
                    r_tr    <= rnd15((PW+1)'(r_acc) + (PW+1)'(r_prod));
                    r_state <= ST_BF_P3;
                end
                ST_BF_P3: begin
                    r_acc   <= r_prod;
                    r_state <= ST_BF_P4;
                end
                ST_BF_P4: begin
                    r_ti    <= rnd15((PW+1)'(r_acc) - (PW+1)'(r_prod));
                    r_state <= ST_BF_WA;
                end
                ST_BF_WA: r_state <= ST_BF_WB;
                ST_BF_WB: begin
                    r_j <= r_j + JW'(1);
                    if (r_j == '1) begin
                        if (r_stage == STW'(LOG2N - 1)) begin
                            r_i     <= '0;
                            r_state <= ST_PW_RD;
                        end else begin
                            r_stage <= r_stage + STW'(1);
                            r_state <= ST_BF_RD;
                        end
                    end else begin
                        r_state <= ST_BF_RD;
                    end
                end
                ST_PW_RD: r_state <= ST_PW_M0;
                ST_PW_M0: r_state <= ST_PW_M1;
                ST_PW_M1: begin
                    r_acc   <= r_prod;
                    r_state <= ST_PW_M2;
                end
                ST_PW_M2: begin
                    r_i <= r_i + ACW'(1);
                    if (r_i == ACW'(NBINS - 1)) begin
                        if (!cc_last) begin
                            r_cc    <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_cc    <= 1'b0;
                            r_b     <= '0;
                            r_k     <= '0;
                            r_idx   <= '0;
                            r_sum   <= '0;
                            r_state <= ST_BD_RD;
                        end
                    end else begin
                        r_state <= ST_PW_RD;
                    end
                end
                ST_BD_RD: begin
                    r_inrange <= (r_idx < NBINS);
                    r_state   <= ST_BD_ADD;
                end
                ST_BD_ADD: begin
                    r_sum <= bd_sum[64] ? '1 : bd_sum[63:0];
                    r_idx <= r_idx + IDXW'(1);
                    if (r_k + 9'd1 < width) begin
                        r_k     <= r_k + 9'd1;
                        r_state <= ST_BD_RD;
                    end else begin
                        r_state <= ST_BD_S0;
                    end
                end
                ST_BD_S0: r_state <= ST_BD_S1;
                ST_BD_S1: begin
                    r_acc   <= r_prod;
                    r_state <= ST_BD_S2;
                end
                ST_BD_S2: begin
                    r_band  <= (bd_scaled > POWER_MAX) ? POWER_MAX : bd_scaled;
                    r_state <= ST_BD_OUT;
                end
                ST_BD_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_idx   <= BAND_IDX_W'(r_b);
                        r_out_pow   <= r_band[POWER_W-1:0];
                        r_out_last  <= (r_b + BW'(1) == bands);
                        r_b         <= r_b + BW'(1);
                        r_k         <= '0;
                        r_sum       <= '0;
                        r_state     <= (r_b + BW'(1) == bands) ? ST_IDLE : ST_BD_RD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{(M_TDATA_W - POWER_W - BAND_IDX_W){1'b0}}, r_out_pow, r_out_idx};

`ifndef NO_ASSERTIONS
    a_out_from_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_BD_OUT))
        else $error("band beat raised outside the output step");

    a_bypass_only_k0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BF_P1) |-> (bf_k != '0))
        else $error("twiddle multiply on a unity butterfly");

    a_bin_in_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BD_ADD) |-> (r_k < width))
        else $error("bin counter ran past the band width");

    a_butterfly_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BF_WB) |-> $past(r_state == ST_BF_WA))
        else $error("butterfly write order broken");
`endif

endmodule
